FILE: rtl/isort_pkg.sv
// ---------------------------------------------------------------------------
// isort_pkg: shared types and constants of the integer array sorter
// Store depth, derived index widths and the element type.
// ---------------------------------------------------------------------------
`default_nettype none

package isort_pkg;

    // Number of elements in one set (1 .. 64)
    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic signed [DATA_W-1:0] value_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         count_t;

endpackage : isort_pkg

`default_nettype wire

FILE: rtl/isort_ram.sv
// ---------------------------------------------------------------------------
// isort_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module isort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule : isort_ram

`default_nettype wire

FILE: rtl/integer_array_sorter_core.sv
// ---------------------------------------------------------------------------
// integer_array_sorter_core: collect a set of signed integers, emit sorted
// Insertion sort into a RAM on each request, ascending emission once the set closes.
// ---------------------------------------------------------------------------
//
//  Channel | Handshake           | Payload               | Direction
//  --------+---------------------+-----------------------+----------
//  in      | in_valid / in_stall | value, last           | into core
//  out     | out_valid/out_stall | sorted_value,final_res| out of core
//
//  Each input request is inserted into the element RAM as it arrives: one
//  shared signed comparator walks down from the top of the stored set, and
//  every element larger than the new one is moved up one slot. After the
//  accept edge in_stall stays high while each stored element greater than
//  the new one is read (S_READ) and shifted (S_CMP); a last compare then
//  places the new one, or S_READ writes it when it lands in slot 0. The
//  single RAM read port with its registered output sets that two-step walk.
//  A request marked last (or the one that fills the store) then starts the
//  emission: each result is read, loaded and held while out_stall is high.
//  Reset clears the sequencer and the element count; the RAM needs no clear
//  since a set only reads the slots it wrote itself.
//
// ---------------------------------------------------------------------------
`default_nettype none

module integer_array_sorter_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input request channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire isort_pkg::value_t value,
    input  wire logic              last,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output isort_pkg::value_t      sorted_value,
    output logic                   final_res
);

    import isort_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0; // waiting for a request
    localparam logic [2:0] S_READ    = 3'd1; // fetch element below the hole
    localparam logic [2:0] S_CMP     = 3'd2; // compare, shift up or place key
    localparam logic [2:0] S_EMIT_RD = 3'd3; // fetch next sorted element
    localparam logic [2:0] S_EMIT_LD = 3'd4; // load output register
    localparam logic [2:0] S_EMIT_OUT = 3'd5; // hold result until taken

    logic [2:0] state_reg, state_next;
    count_t     count_reg, count_next;
    logic       out_valid_reg, out_valid_next;

    // Datapath registers, no reset needed
    value_t     key_reg, key_next;       // element being inserted
    logic       last_reg, last_next;     // set closes after this insert
    addr_t      hole_reg, hole_next;     // free slot the key moves through
    addr_t      emit_reg, emit_next;     // emission index
    value_t     res_reg, res_next;
    logic       fin_reg, fin_next;

    // RAM port signals
    logic       ram_we;
    addr_t      ram_waddr;
    value_t     ram_wdata;
    addr_t      ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    value_t     ram_rval;

    // Shared comparator and helpers
    logic       key_less;
    logic       set_done;
    count_t     count_m1;
    addr_t      last_idx;

    isort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign ram_rval = value_t'(ram_rdata);
    assign key_less = (key_reg < ram_rval);
    // Set closes on a last mark or once the store is full
    assign set_done = last_reg || (count_reg == count_t'(DEPTH));
    assign count_m1 = count_reg - count_t'(1);
    assign last_idx = count_m1[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        key_next       = key_reg;
        last_next      = last_reg;
        hole_next      = hole_reg;
        emit_next      = emit_reg;
        res_next       = res_reg;
        fin_next       = fin_reg;
        ram_we         = 1'b0;
        ram_waddr      = hole_reg;
        ram_wdata      = key_reg;
        ram_raddr      = hole_reg - addr_t'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next   = value;
                    last_next  = last;
                    hole_next  = count_reg[ADDR_W-1:0];
                    count_next = count_reg + count_t'(1);
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                if (hole_reg == addr_t'(0))
                begin
                    // bottom reached: key is the smallest so far
                    ram_we = 1'b1;
                    if (set_done)
                    begin
                        emit_next  = addr_t'(0);
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                ram_we = 1'b1;
                if (key_less)
                begin
                    // move larger element up into the hole
                    ram_wdata  = ram_rval;
                    hole_next  = hole_reg - addr_t'(1);
                    state_next = S_READ;
                end
                else if (set_done)
                begin
                    emit_next  = addr_t'(0);
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_EMIT_RD:
            begin
                ram_raddr  = emit_reg;
                state_next = S_EMIT_LD;
            end

            S_EMIT_LD:
            begin
                res_next       = ram_rval;
                fin_next       = (emit_reg == last_idx);
                out_valid_next = 1'b1;
                state_next     = S_EMIT_OUT;
            end

            S_EMIT_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (fin_reg)
                    begin
                        count_next = count_t'(0);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_next  = emit_reg + addr_t'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= count_t'(0);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        last_reg <= last_next;
        hole_reg <= hole_next;
        emit_reg <= emit_next;
        res_reg  <= res_next;
        fin_reg  <= fin_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign sorted_value = res_reg;
    assign final_res    = fin_reg;

endmodule : integer_array_sorter_core

`default_nettype wire
